// ===== rtl/scfb_pkg.sv =====
// shared types and constants for the sensor command frame builder
`default_nettype none

package scfb_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;
    localparam int ADDR_W = 32;
    localparam int SUM_W  = 16;
    localparam int HDR_W  = 16;

    // payload limit, payload lengths above it are clamped
    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 9'd256;
    localparam logic [LEN_W-1:0] LEN_OVERHEAD = 9'd2;

    // reset values of the configuration registers
    localparam logic [HDR_W-1:0]  HEADER_RESET  = 16'hEF01;
    localparam logic [ADDR_W-1:0] DEF_ADDR_RESET = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_WORD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ADDRESS = 2'd1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // byte positions within a frame
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_HDR_HI = 4'd0;
    localparam logic [STEP_W-1:0] STEP_HDR_LO = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ADDR3  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ADDR2  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ADDR1  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ADDR0  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ID     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LEN_HI = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LEN_LO = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DATA   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_CS_HI  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_CS_LO  = 4'd11;

    // one classified item, as the back end needs it
    typedef struct packed {
        logic               start;
        logic               has_data;
        logic               last;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  id;
        logic [LEN_W-1:0]   len_word;
        logic [BYTE_W-1:0]  data;
        logic [SUM_W-1:0]   csum;
    } scfb_entry_t;

endpackage

`default_nettype wire

// ===== rtl/scfb_front.sv =====
// front end: accepts items, tracks frame position and checksum, classifies
`default_nettype none

module scfb_front
    import scfb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_packet_id,
    input  wire logic [LEN_W-1:0]  s_payload_length,
    input  wire logic [ADDR_W-1:0] s_target_address,
    input  wire logic [BYTE_W-1:0] s_data_byte,
    input  wire logic [ADDR_W-1:0] default_address,
    input  wire logic              queue_full,
    output logic                   queue_push,
    output scfb_entry_t            queue_entry
);

    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] csum_reg, csum_next;

    logic             opening;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] len_word;
    logic [SUM_W-1:0] start_sum;
    logic [SUM_W-1:0] base_sum;
    logic [LEN_W-1:0] base_rem;
    logic [LEN_W-1:0] rem_dec;
    logic [SUM_W-1:0] sum_with;
    logic             has_data;
    logic             last;

    assign s_ready    = !queue_full;
    assign queue_push = s_valid && s_ready;

    // classify the item and fold its byte into the checksum
    always_comb begin
        opening   = (rem_reg == '0);
        len_sat   = (s_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : s_payload_length;
        len_word  = len_sat + LEN_OVERHEAD;
        start_sum = SUM_W'({8'b0, s_packet_id}) + SUM_W'({7'b0, len_word});
        base_sum  = opening ? start_sum : csum_reg;
        base_rem  = opening ? len_sat : rem_reg;
        has_data  = (base_rem != '0);
        rem_dec   = base_rem - 9'd1;
        sum_with  = base_sum + SUM_W'({8'b0, s_data_byte});
        last      = !has_data || (rem_dec == '0);

        queue_entry.start    = opening;
        queue_entry.has_data = has_data;
        queue_entry.last     = last;
        queue_entry.addr     = (s_target_address == '0) ? default_address : s_target_address;
        queue_entry.id       = s_packet_id;
        queue_entry.len_word = len_word;
        queue_entry.data     = s_data_byte;
        queue_entry.csum     = has_data ? sum_with : base_sum;

        rem_next  = rem_reg;
        csum_next = csum_reg;
        if (queue_push) begin
            rem_next  = has_data ? rem_dec : '0;
            csum_next = last ? '0 : sum_with;
        end
    end

    // frame position and running checksum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            csum_reg <= '0;
        end else begin
            rem_reg  <= rem_next;
            csum_reg <= csum_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scfb_queue.sv =====
// short queue of classified items between front and back
`default_nettype none

module scfb_queue
    import scfb_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire scfb_entry_t push_entry,
    output logic       full,
    input  wire logic  pop,
    output scfb_entry_t head,
    output logic       empty
);

    scfb_entry_t       mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scfb_back.sv =====
// back end: walks each queued item through its frame bytes into the output register
`default_nettype none

module scfb_back
    import scfb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire scfb_entry_t       head,
    input  wire logic              queue_empty,
    output logic                   queue_pop,
    input  wire logic [HDR_W-1:0]  header_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_frame_end
);

    logic              in_prog_reg, in_prog_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              end_reg, end_next;

    logic              load;
    logic [STEP_W-1:0] first_step;
    logic [STEP_W-1:0] cur_step;
    logic [STEP_W-1:0] follow_step;
    logic              done;
    logic [BYTE_W-1:0] sel_byte;

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_frame_end = end_reg;

    // step selection for the item at the head of the queue
    always_comb begin
        if (head.start) begin
            first_step = STEP_HDR_HI;
        end else if (head.has_data) begin
            first_step = STEP_DATA;
        end else begin
            first_step = STEP_CS_HI;
        end
        cur_step = in_prog_reg ? step_reg : first_step;
        load     = !queue_empty && (!valid_reg || m_ready);

        done        = 1'b0;
        follow_step = cur_step + 1'b1;
        case (cur_step)
            STEP_LEN_LO: begin
                follow_step = head.has_data ? STEP_DATA : STEP_CS_HI;
            end
            STEP_DATA: begin
                done = !head.last;
            end
            STEP_CS_LO: begin
                done = 1'b1;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    // byte for the current step
    always_comb begin
        case (cur_step)
            STEP_HDR_HI: sel_byte = header_word[15:8];
            STEP_HDR_LO: sel_byte = header_word[7:0];
            STEP_ADDR3:  sel_byte = head.addr[31:24];
            STEP_ADDR2:  sel_byte = head.addr[23:16];
            STEP_ADDR1:  sel_byte = head.addr[15:8];
            STEP_ADDR0:  sel_byte = head.addr[7:0];
            STEP_ID:     sel_byte = head.id;
            STEP_LEN_HI: sel_byte = {7'b0, head.len_word[8]};
            STEP_LEN_LO: sel_byte = head.len_word[7:0];
            STEP_DATA:   sel_byte = head.data;
            STEP_CS_HI:  sel_byte = head.csum[15:8];
            STEP_CS_LO:  sel_byte = head.csum[7:0];
            default:     sel_byte = '0;
        endcase
    end

    // sequencer and output register update
    always_comb begin
        queue_pop    = 1'b0;
        in_prog_next = in_prog_reg;
        step_next    = step_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        end_next     = end_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            byte_next  = sel_byte;
            end_next   = (cur_step == STEP_CS_LO);
            if (done) begin
                queue_pop    = 1'b1;
                in_prog_next = 1'b0;
            end else begin
                in_prog_next = 1'b1;
                step_next    = follow_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_prog_reg <= 1'b0;
            step_reg    <= STEP_HDR_HI;
            valid_reg   <= 1'b0;
        end else begin
            in_prog_reg <= in_prog_next;
            step_reg    <= step_next;
            valid_reg   <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

    // the queue head stays put while its frame bytes are being sent
    a_in_prog_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        in_prog_reg |-> !queue_empty)
        else $error("sequencer mid-item with empty queue");

    // a pop only happens together with a byte load
    a_pop_with_load: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_pop |-> load)
        else $error("queue popped without a byte load");

    // the closing checksum byte always retires its item
    a_cs_lo_retires: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && cur_step == STEP_CS_LO) |-> queue_pop)
        else $error("checksum low byte did not retire the item");

    // a held step never runs past the closing checksum byte
    a_step_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        in_prog_reg |-> (step_reg <= STEP_CS_LO))
        else $error("frame step out of range");

endmodule

`default_nettype wire

// ===== rtl/sensor_command_frame_builder.sv =====
// top level of the sensor command frame builder: config registers, front, queue and back
//
// Input channel (s_*): one beat per payload byte. A beat that arrives with no
// frame open also carries packet id, payload length and address and opens a
// frame; a zero-length frame is complete from that one beat.
// Output channel (m_*): one frame byte per beat, header, address, id, length
// word, payload, then the checksum; m_frame_end marks the low checksum byte.
// Config channel (cfg_*): always ready; index 0 is the header word, index 1
// the default address, other indexes are ignored. Write only while idle.
// An input beat is registered in the queue, then its first byte in the output
// register on m_*. One output byte per cycle, set by the single output register,
// unless m_ready is low or the queue is empty: a mid-frame beat yields one byte,
// the last payload beat three, and a frame-opening beat ten to twelve.
// A two-entry queue sits between the input side and the byte sequencer, so
// input beats keep flowing while the output stalls until the queue fills;
// a stalled output byte is held steady.
// Reset clears frame position, checksum, queue and output valid, and loads
// the header word 0xEF01 and default address 0xFFFFFFFF.
`default_nettype none

module sensor_command_frame_builder
    import scfb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_packet_id,
    input  wire logic [LEN_W-1:0]     s_payload_length,
    input  wire logic [ADDR_W-1:0]    s_target_address,
    input  wire logic [BYTE_W-1:0]    s_data_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [BYTE_W-1:0]         m_out_byte,
    output logic                      m_frame_end,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    logic [HDR_W-1:0]  header_reg, header_next;
    logic [ADDR_W-1:0] def_addr_reg, def_addr_next;

    logic        queue_full;
    logic        queue_empty;
    logic        queue_push;
    logic        queue_pop;
    scfb_entry_t push_entry;
    scfb_entry_t head_entry;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_comb begin
        header_next   = header_reg;
        def_addr_next = def_addr_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HEADER_WORD:     header_next   = cfg_data[HDR_W-1:0];
                CFG_DEFAULT_ADDRESS: def_addr_next = cfg_data;
                default:             header_next   = header_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg   <= HEADER_RESET;
            def_addr_reg <= DEF_ADDR_RESET;
        end else begin
            header_reg   <= header_next;
            def_addr_reg <= def_addr_next;
        end
    end

    // input side
    scfb_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_packet_id      (s_packet_id),
        .s_payload_length (s_payload_length),
        .s_target_address (s_target_address),
        .s_data_byte      (s_data_byte),
        .default_address  (def_addr_reg),
        .queue_full       (queue_full),
        .queue_push       (queue_push),
        .queue_entry      (push_entry)
    );

    // decoupling queue
    scfb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (queue_push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (queue_pop),
        .head       (head_entry),
        .empty      (queue_empty)
    );

    // byte sequencer and output register
    scfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head_entry),
        .queue_empty (queue_empty),
        .queue_pop   (queue_pop),
        .header_word (header_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end)
    );

endmodule

`default_nettype wire

// ===== test/sensor_command_frame_builder_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the sensor command frame builder
module sensor_command_frame_builder_test
    import scfb_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BEATS   = 72;
    localparam int RANDOM_ROUNDS  = 4;
    localparam int TAIL_BEATS     = 12;
    localparam int PRINT_LIMIT    = 40;
    localparam int FRAME_W        = 88;

    // indexes outside the register map, writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    // one line of the directed table
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [ADDR_W-1:0]       reg_val;
        logic [BYTE_W-1:0]       id;
        logic [LEN_W-1:0]        len;
        logic [ADDR_W-1:0]       addr;
        logic [BYTE_W-1:0]       data;
        logic                    typed;
        logic [FRAME_W-1:0]      frame;  // whole zero-length frame, first byte on top
    } row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_byte_t;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_packet_id      = '0;
    logic [LEN_W-1:0]     s_payload_length = '0;
    logic [ADDR_W-1:0]    s_target_address = '0;
    logic [BYTE_W-1:0]    s_data_byte      = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b1;
    logic [BYTE_W-1:0]    m_out_byte;
    logic                 m_frame_end;
    logic                 cfg_valid        = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [ADDR_W-1:0]    cfg_data         = '0;

    // predictor copy of registers and frame state
    logic [HDR_W-1:0]     hdr_word_q   = HEADER_RESET;
    logic [ADDR_W-1:0]    dflt_addr_q  = DEF_ADDR_RESET;
    logic [LEN_W-1:0]     payload_left = '0;
    logic [SUM_W-1:0]     csum_acc     = '0;

    frame_byte_t pending_bytes[$];  // expected frame bytes, oldest first
    frame_byte_t beat_bytes[$];     // bytes caused by the latest input beat
    frame_byte_t oldest;
    row_t        directed[$];

    int  mismatches     = 0;
    int  beats_sent     = 0;
    int  frames_opened  = 0;
    int  frames_closed  = 0;
    int  bytes_checked  = 0;
    int  reg_writes     = 0;
    int  src_gap_pct    = 0;
    int  sink_stall_pct = 0;
    int  sink_gap       = 0;
    int  quiet_cycles   = 0;
    bit  src_up         = 1'b0;

    sensor_command_frame_builder u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_packet_id      (s_packet_id),
        .s_payload_length (s_payload_length),
        .s_target_address (s_target_address),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_frame_end      (m_frame_end),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // checksum closes the frame, low byte flagged as frame end
    task automatic close_frame();
        beat_bytes.push_back({csum_acc[15:8], 1'b0});
        beat_bytes.push_back({csum_acc[7:0], 1'b1});
        csum_acc = '0;
    endtask

    // frame bytes caused by one input beat
    task automatic predict_beat(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len,
                                input logic [ADDR_W-1:0] addr,
                                input logic [BYTE_W-1:0] data);
        logic [LEN_W-1:0]  take;
        logic [SUM_W-1:0]  len_word;
        logic [ADDR_W-1:0] dest;
        beat_bytes.delete();
        if (payload_left == '0) begin
            // opening beat: clamp length, pick address, emit the frame head
            take     = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
            len_word = SUM_W'(take) + SUM_W'(LEN_OVERHEAD);
            dest     = (addr == '0) ? dflt_addr_q : addr;
            beat_bytes.push_back({hdr_word_q[15:8], 1'b0});
            beat_bytes.push_back({hdr_word_q[7:0], 1'b0});
            for (int k = 3; k >= 0; k--) begin
                beat_bytes.push_back({dest[8*k +: 8], 1'b0});
            end
            beat_bytes.push_back({id, 1'b0});
            beat_bytes.push_back({len_word[15:8], 1'b0});
            beat_bytes.push_back({len_word[7:0], 1'b0});
            csum_acc     = SUM_W'(id) + len_word;
            payload_left = take;
            frames_opened++;
            if (take == '0) begin
                close_frame();
                return;
            end
        end
        // payload byte
        beat_bytes.push_back({data, 1'b0});
        csum_acc     = csum_acc + SUM_W'(data);
        payload_left = payload_left - 1'b1;
        if (payload_left == '0) begin
            close_frame();
        end
    endtask

    // drive one input beat, optionally after a random gap
    task automatic send_beat(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len,
                             input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data,
                             input logic typed, input logic [FRAME_W-1:0] frame);
        int gap;
        if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            gap = $urandom_range(8, 1);
            if (src_up) begin
                s_valid <= 1'b0;
            end
            src_up = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        src_up            = 1'b1;
        s_packet_id      <= id;
        s_payload_length <= len;
        s_target_address <= addr;
        s_data_byte      <= data;
        do @(posedge aclk); while (!s_ready);
        predict_beat(id, len, addr, data);
        if (typed) begin
            for (int k = 10; k >= 0; k--) begin
                pending_bytes.push_back({frame[8*k +: 8], k == 0});
            end
        end else begin
            foreach (beat_bytes[k]) begin
                pending_bytes.push_back(beat_bytes[k]);
            end
        end
        beats_sent++;
    endtask

    // stop sending and let every expected byte come out
    task automatic settle();
        if (src_up) begin
            s_valid <= 1'b0;
        end
        src_up = 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HEADER_WORD:     hdr_word_q  = val[HDR_W-1:0];
            CFG_DEFAULT_ADDRESS: dflt_addr_q = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // one well-formed frame with random content, mid-frame fields are noise
    task automatic send_random_frame();
        logic [LEN_W-1:0] len;
        int               pick;
        int               beats;
        pick = $urandom_range(99);
        if (pick < 25) begin
            len = '0;
        end else if (pick < 85) begin
            len = LEN_W'($urandom_range(8, 1));
        end else begin
            len = LEN_W'($urandom_range(24, 9));
        end
        beats = (len == '0) ? 1 : int'(len);
        send_beat(BYTE_W'($urandom), len,
                  ($urandom_range(3) == 0) ? '0 : ADDR_W'($urandom),
                  BYTE_W'($urandom), 1'b0, '0);
        for (int k = 1; k < beats; k++) begin
            send_beat(BYTE_W'($urandom), LEN_W'($urandom), ADDR_W'($urandom),
                      BYTE_W'($urandom), 1'b0, '0);
        end
    endtask

    function automatic row_t beat_row(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [BYTE_W-1:0] data);
        row_t r;
        r       = '0;
        r.kind  = ROW_BEAT;
        r.id    = id;
        r.len   = len;
        r.addr  = addr;
        r.data  = data;
        return r;
    endfunction

    function automatic row_t frame_row(input logic [BYTE_W-1:0] id,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [BYTE_W-1:0] data,
                                       input logic [FRAME_W-1:0] frame);
        row_t r;
        r       = beat_row(id, '0, addr, data);
        r.typed = 1'b1;
        r.frame = frame;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [ADDR_W-1:0] val);
        row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // output stalls in random bursts
    always @(posedge aclk) begin
        if (sink_gap != 0) begin
            sink_gap--;
            if (sink_gap == 0) begin
                m_ready <= 1'b1;
            end
        end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
            sink_gap = $urandom_range(8, 1);
            m_ready <= 1'b0;
        end
    end

    // compare each output beat with the oldest expected byte
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h end %b",
                                          m_out_byte, m_frame_end));
            end else begin
                oldest = pending_bytes.pop_front();
                if (m_out_byte !== oldest.data) begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              m_out_byte, oldest.data));
                end
                if (m_frame_end !== oldest.last) begin
                    report_mismatch($sformatf("frame_end %b, expected %b",
                                              m_frame_end, oldest.last));
                end
                bytes_checked++;
                if (oldest.last) begin
                    frames_closed++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d bytes outstanding",
                         quiet_cycles, pending_bytes.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [ADDR_W-1:0] dflt_pick;
        int                round_start;

        // directed table: zero-length frames after reset and at register extremes are typed
        directed.push_back(frame_row(8'h00, 32'h0000_0000, 8'hAA,
                                     88'hEF01_FFFF_FFFF_00_0002_0002));
        directed.push_back(frame_row(8'hFF, 32'hFFFF_FFFF, 8'h55,
                                     88'hEF01_FFFF_FFFF_FF_0002_0101));
        directed.push_back(beat_row(8'h5A, 9'd1, 32'h1234_5678, 8'hFF));
        // three-byte frame, later beats carry header fields that must be ignored
        directed.push_back(beat_row(8'h01, 9'd3, 32'h8000_0001, 8'h00));
        directed.push_back(beat_row(8'hFF, 9'h1FF, 32'h0000_0000, 8'hFF));
        directed.push_back(beat_row(8'h00, 9'd0, 32'hFFFF_FFFF, 8'h80));
        directed.push_back(beat_row(8'h7E, 9'd2, 32'h0000_0001, 8'h01));
        directed.push_back(beat_row(8'h81, 9'h100, 32'h7FFF_FFFE, 8'hFE));
        // header all ones, default address zero
        directed.push_back(cfg_row(CFG_HEADER_WORD, 32'h0000_FFFF));
        directed.push_back(cfg_row(CFG_DEFAULT_ADDRESS, 32'h0000_0000));
        directed.push_back(frame_row(8'h00, 32'h0000_0000, 8'h00,
                                     88'hFFFF_0000_0000_00_0002_0002));
        // writes to unmapped indexes leave the registers alone
        directed.push_back(cfg_row(CFG_SPARE_3, 32'hFFFF_FFFF));
        directed.push_back(cfg_row(CFG_SPARE_2, 32'h0000_0000));
        directed.push_back(frame_row(8'h10, 32'h0000_0000, 8'hFF,
                                     88'hFFFF_0000_0000_10_0002_0012));
        // header all zeros
        directed.push_back(cfg_row(CFG_HEADER_WORD, 32'hFFFF_0000));
        directed.push_back(cfg_row(CFG_DEFAULT_ADDRESS, 32'hA5C3_0F96));
        directed.push_back(frame_row(8'hC3, 32'h0000_0000, 8'h00,
                                     88'h0000_A5C3_0F96_C3_0002_00C5));
        directed.push_back(beat_row(8'h3C, 9'd2, 32'h0000_0000, 8'h7F));
        directed.push_back(beat_row(8'h00, 9'd0, 32'h0000_0000, 8'h00));

        // reset
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        foreach (directed[r]) begin
            if (directed[r].kind == ROW_CFG) begin
                write_reg(directed[r].reg_idx, directed[r].reg_val);
            end else begin
                send_beat(directed[r].id, directed[r].len, directed[r].addr,
                          directed[r].data, directed[r].typed, directed[r].frame);
            end
        end

        // random part, new register settings each round
        for (int rnd = 0; rnd < RANDOM_ROUNDS; rnd++) begin
            case ($urandom_range(3))
                0:       dflt_pick = '0;
                1:       dflt_pick = '1;
                default: dflt_pick = ADDR_W'($urandom);
            endcase
            write_reg(CFG_HEADER_WORD, ADDR_W'($urandom));
            write_reg(CFG_DEFAULT_ADDRESS, dflt_pick);
            if ($urandom_range(1) == 0) begin
                write_reg(($urandom_range(1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                          ADDR_W'($urandom));
            end
            src_gap_pct    = (rnd == 1) ? 0 : $urandom_range(40, 10);
            sink_stall_pct = (rnd == 2) ? 0 : $urandom_range(50, 10);
            round_start    = beats_sent;
            while (beats_sent - round_start < RANDOM_BEATS / RANDOM_ROUNDS) begin
                send_random_frame();
            end
        end

        // closing stretch at full rate, no idling on either side
        write_reg(CFG_HEADER_WORD, {16'h0000, HEADER_RESET});
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        round_start    = beats_sent;
        while (beats_sent - round_start < TAIL_BEATS) begin
            send_random_frame();
        end

        settle();
        $display("coverage: %0d input beats, %0d frames opened, %0d closed, %0d bytes checked",
                 beats_sent, frames_opened, frames_closed, bytes_checked);
        $display("coverage: %0d register writes, payloads of 0 to 24 bytes, last stretch unstalled",
                 reg_writes);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
